[src/ctc_pkg.sv]
// Shared constants and types for the CTC greedy decoder.
package ctc_pkg;

    localparam int SCORE_W         = 16;
    localparam int CLASS_W         = 14;
    localparam int CFG_W           = 15;
    localparam int MAX_TIMESTEPS   = 1024;
    localparam int CNT_W           = $clog2(MAX_TIMESTEPS + 1);
    localparam int SUM_W           = SCORE_W + CNT_W;
    localparam int MIN_CLASSES     = 2;
    localparam int MAX_CLASSES     = 16384;
    localparam int NUM_CLASSES_RST = 6626;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int STEP_W          = $clog2(SUM_W + 1);

    // one queued result, with the sequence totals snapshot for the mean
    typedef struct packed {
        logic                      token_valid;
        logic [CLASS_W-1:0]        token_index;
        logic signed [SCORE_W-1:0] token_score;
        logic                      seq_done;
        logic signed [SUM_W-1:0]   sum;
        logic [CNT_W-1:0]          count;
    } entry_t;

    typedef struct packed {
        logic                      token_valid;
        logic [CLASS_W-1:0]        token_index;
        logic signed [SCORE_W-1:0] token_score;
        logic                      seq_done;
        logic [SCORE_W-1:0]        mean_score;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

[src/ctc_ifs.sv]
// Stream interfaces for the score input and the result output.
interface ctc_score_if;
    logic                                valid;
    logic                                ready;
    logic signed [ctc_pkg::SCORE_W-1:0]  class_score;
    logic                                seq_end;

    modport source (output valid, output class_score, output seq_end, input ready);
    modport sink   (input valid, input class_score, input seq_end, output ready);
endinterface

interface ctc_result_if;
    logic                                valid;
    logic                                ready;
    logic                                token_valid;
    logic [ctc_pkg::CLASS_W-1:0]         token_index;
    logic signed [ctc_pkg::SCORE_W-1:0]  token_score;
    logic                                seq_done;
    logic [ctc_pkg::SCORE_W-1:0]         mean_score;

    modport source (output valid, output token_valid, output token_index,
                    output token_score, output seq_done, output mean_score,
                    input ready);
    modport sink   (input valid, input token_valid, input token_index,
                    input token_score, input seq_done, input mean_score,
                    output ready);
endinterface

[src/ctc_front.sv]
// Front end: running argmax, row evaluation and token accounting.
module ctc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ctc_pkg::CLASS_W-1:0]   last_pos,
    input  logic                          queue_full,
    ctc_score_if.sink                     score,
    output logic                          push,
    output ctc_pkg::entry_t               entry
);

    logic [ctc_pkg::CLASS_W-1:0]        class_pos_reg, class_pos_next;
    logic signed [ctc_pkg::SCORE_W-1:0] best_value_reg, best_value_next;
    logic [ctc_pkg::CLASS_W-1:0]        best_class_reg, best_class_next;
    logic [ctc_pkg::CLASS_W-1:0]        prev_winner_reg, prev_winner_next;
    logic                               prev_known_reg, prev_known_next;
    logic signed [ctc_pkg::SUM_W-1:0]   score_sum_reg, score_sum_next;
    logic [ctc_pkg::CNT_W-1:0]          token_count_reg, token_count_next;

    logic                               fire;
    logic                               take;
    logic signed [ctc_pkg::SCORE_W-1:0] cur_value;
    logic [ctc_pkg::CLASS_W-1:0]        cur_class;
    logic                               row_end;
    logic                               tok;
    logic                               counted;
    logic signed [ctc_pkg::SUM_W-1:0]   sum_upd;
    logic [ctc_pkg::CNT_W-1:0]          cnt_upd;

    assign score.ready = !queue_full;
    assign fire        = score.valid && score.ready;

    assign take      = (class_pos_reg == '0) || (score.class_score > best_value_reg);
    assign cur_value = take ? score.class_score : best_value_reg;
    assign cur_class = take ? class_pos_reg : best_class_reg;
    assign row_end   = (class_pos_reg >= last_pos);
    assign tok       = row_end && (cur_class != '0)
                       && (!prev_known_reg || (cur_class != prev_winner_reg));
    assign counted   = tok
                       && (token_count_reg < ctc_pkg::CNT_W'(ctc_pkg::MAX_TIMESTEPS));

    assign sum_upd = counted
        ? score_sum_reg + {{(ctc_pkg::SUM_W-ctc_pkg::SCORE_W){cur_value[ctc_pkg::SCORE_W-1]}},
                           cur_value}
        : score_sum_reg;
    assign cnt_upd = counted ? token_count_reg + ctc_pkg::CNT_W'(1) : token_count_reg;

    assign push = fire && (tok || score.seq_end);

    always_comb
    begin
        entry.token_valid = tok;
        entry.token_index = tok ? cur_class - ctc_pkg::CLASS_W'(1) : '0;
        entry.token_score = tok ? cur_value : '0;
        entry.seq_done    = score.seq_end;
        entry.sum         = sum_upd;
        entry.count       = cnt_upd;
    end

    always_comb
    begin
        class_pos_next   = class_pos_reg;
        best_value_next  = best_value_reg;
        best_class_next  = best_class_reg;
        prev_winner_next = prev_winner_reg;
        prev_known_next  = prev_known_reg;
        score_sum_next   = score_sum_reg;
        token_count_next = token_count_reg;
        if (fire)
        begin
            best_value_next  = cur_value;
            best_class_next  = cur_class;
            score_sum_next   = sum_upd;
            token_count_next = cnt_upd;
            if (row_end)
            begin
                prev_winner_next = cur_class;
                prev_known_next  = 1'b1;
                class_pos_next   = '0;
            end
            else
            begin
                class_pos_next = class_pos_reg + ctc_pkg::CLASS_W'(1);
            end
            if (score.seq_end)
            begin
                class_pos_next   = '0;
                best_value_next  = '0;
                best_class_next  = '0;
                prev_winner_next = '0;
                prev_known_next  = 1'b0;
                score_sum_next   = '0;
                token_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_pos_reg   <= '0;
            best_value_reg  <= '0;
            best_class_reg  <= '0;
            prev_winner_reg <= '0;
            prev_known_reg  <= 1'b0;
            score_sum_reg   <= '0;
            token_count_reg <= '0;
        end
        else
        begin
            class_pos_reg   <= class_pos_next;
            best_value_reg  <= best_value_next;
            best_class_reg  <= best_class_next;
            prev_winner_reg <= prev_winner_next;
            prev_known_reg  <= prev_known_next;
            score_sum_reg   <= score_sum_next;
            token_count_reg <= token_count_next;
        end
    end

endmodule

[src/ctc_queue.sv]
// Small FIFO between front and back ends.
module ctc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctc_pkg::queue_ctl_t  ctl,
    input  ctc_pkg::entry_t      wr_data,
    output ctc_pkg::entry_t      rd_data,
    output ctc_pkg::queue_stat_t stat
);

    ctc_pkg::entry_t             mem_reg [ctc_pkg::QUEUE_DEPTH];
    logic [ctc_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ctc_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ctc_pkg::QPTR_W:0]    fill_reg, fill_next;
    logic                        do_push;
    logic                        do_pop;

    assign stat.full  = (fill_reg == (ctc_pkg::QPTR_W+1)'(ctc_pkg::QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign do_push    = ctl.push && !stat.full;
    assign do_pop     = ctl.pop && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + ctc_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + ctc_pkg::QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + (ctc_pkg::QPTR_W+1)'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - (ctc_pkg::QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[src/ctc_back.sv]
// Back end: mean divider and output register.
module ctc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctc_pkg::entry_t      head,
    input  ctc_pkg::queue_stat_t stat,
    output logic                 pop,
    ctc_result_if.source         result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } state_t;

    localparam logic [ctc_pkg::SUM_W-1:0] SCORE_ONE = ctc_pkg::SUM_W'(1) << (ctc_pkg::SCORE_W-1);

    state_t                          state_reg, state_next;
    logic                            out_valid_reg, out_valid_next;
    ctc_pkg::result_t                out_reg, out_next;
    ctc_pkg::entry_t                 hold_reg, hold_next;
    logic [ctc_pkg::CNT_W:0]         rem_reg, rem_next;
    logic [ctc_pkg::SUM_W-1:0]       quo_reg, quo_next;
    logic [ctc_pkg::STEP_W-1:0]      step_reg, step_next;

    logic                            slot_free;
    logic                            need_div;
    logic [ctc_pkg::CNT_W:0]         trial;
    logic [ctc_pkg::CNT_W:0]         den;
    logic [ctc_pkg::SCORE_W-1:0]     mean_clamped;

    assign slot_free = !out_valid_reg || result.ready;
    assign need_div  = head.seq_done && (head.count != '0)
                       && !head.sum[ctc_pkg::SUM_W-1] && (head.sum != '0);
    assign den       = {1'b0, hold_reg.count};
    assign trial     = {rem_reg[ctc_pkg::CNT_W-1:0], quo_reg[ctc_pkg::SUM_W-1]};
    assign mean_clamped = (quo_reg > SCORE_ONE) ? SCORE_ONE[ctc_pkg::SCORE_W-1:0]
                                                : quo_reg[ctc_pkg::SCORE_W-1:0];
    assign pop = (state_reg == S_IDLE) && !stat.empty && slot_free;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_next       = out_reg;
        hold_next      = hold_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    if (need_div)
                    begin
                        hold_next  = head;
                        rem_next   = '0;
                        quo_next   = $unsigned(head.sum)
                                     + ctc_pkg::SUM_W'(head.count >> 1);
                        step_next  = ctc_pkg::STEP_W'(ctc_pkg::SUM_W);
                        state_next = S_DIV;
                    end
                    else
                    begin
                        out_valid_next       = 1'b1;
                        out_next.token_valid = head.token_valid;
                        out_next.token_index = head.token_index;
                        out_next.token_score = head.token_score;
                        out_next.seq_done    = head.seq_done;
                        out_next.mean_score  = '0;
                    end
                end
            end
            S_DIV:
            begin
                if (step_reg != '0)
                begin
                    // restoring step: one quotient bit per cycle
                    if (trial >= den)
                    begin
                        rem_next = trial - den;
                        quo_next = {quo_reg[ctc_pkg::SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial;
                        quo_next = {quo_reg[ctc_pkg::SUM_W-2:0], 1'b0};
                    end
                    step_next = step_reg - ctc_pkg::STEP_W'(1);
                end
                else if (slot_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.token_valid = hold_reg.token_valid;
                    out_next.token_index = hold_reg.token_index;
                    out_next.token_score = hold_reg.token_score;
                    out_next.seq_done    = hold_reg.seq_done;
                    out_next.mean_score  = mean_clamped;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.token_valid = out_reg.token_valid;
    assign result.token_index = out_reg.token_index;
    assign result.token_score = out_reg.token_score;
    assign result.seq_done    = out_reg.seq_done;
    assign result.mean_score  = out_reg.mean_score;

endmodule

[src/ctc_greedy_decoder_top.sv]
// Top level of the CTC greedy decoder: config register, front, queue, back.
//
//  channel  | dir | transfer holds
//  ---------+-----+---------------------------------------------------------
//  score    | in  | class_score (Q1.15 signed), seq_end
//  result   | out | token_valid, token_index, token_score, seq_done, mean_score
//  cfg      | in  | cfg_we / cfg_wdata: num_classes, no read-back
//
//  One score transfer per cycle while the queue has room; the front end
//  (argmax compare plus sum update) sets that figure. A row end producing a
//  token gives a result once its entry has passed the queue and the result
//  register. A sequence end with a positive sum runs the back-end restoring
//  divider while the 4-entry queue keeps absorbing front-end results.
//  Reset is asynchronous, active low; num_classes returns to 6626.
//  The result register holds its data while ready is low.
module ctc_greedy_decoder_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ctc_pkg::CFG_W-1:0]   cfg_wdata,
    ctc_score_if.sink                   score,
    ctc_result_if.source                result
);

    logic [ctc_pkg::CFG_W-1:0]   num_classes_reg;
    logic [ctc_pkg::CFG_W-1:0]   eff_classes;
    logic [ctc_pkg::CLASS_W-1:0] last_pos;

    ctc_pkg::entry_t             push_entry;
    ctc_pkg::entry_t             head_entry;
    ctc_pkg::queue_ctl_t         qctl;
    ctc_pkg::queue_stat_t        qstat;
    logic                        push;
    logic                        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_classes_reg <= ctc_pkg::CFG_W'(ctc_pkg::NUM_CLASSES_RST);
        else if (cfg_we)
            num_classes_reg <= cfg_wdata;
    end

    // out-of-range class counts saturate to the legal span
    always_comb
    begin
        priority if (num_classes_reg < ctc_pkg::CFG_W'(ctc_pkg::MIN_CLASSES))
            eff_classes = ctc_pkg::CFG_W'(ctc_pkg::MIN_CLASSES);
        else if (num_classes_reg > ctc_pkg::CFG_W'(ctc_pkg::MAX_CLASSES))
            eff_classes = ctc_pkg::CFG_W'(ctc_pkg::MAX_CLASSES);
        else
            eff_classes = num_classes_reg;
    end

    assign last_pos = ctc_pkg::CLASS_W'(eff_classes - ctc_pkg::CFG_W'(1));

    assign qctl.push = push;
    assign qctl.pop  = pop;

    ctc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .last_pos   (last_pos),
        .queue_full (qstat.full),
        .score      (score),
        .push       (push),
        .entry      (push_entry)
    );

    ctc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (qctl),
        .wr_data (push_entry),
        .rd_data (head_entry),
        .stat    (qstat)
    );

    ctc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head_entry),
        .stat   (qstat),
        .pop    (pop),
        .result (result)
    );

endmodule
